// ===== sv/msp_pkg.sv =====
// Shared types and fixed widths for the matrix saddle point finder.
// No dependencies; imported by the top level.
`default_nettype none

package msp_pkg;

    localparam int DATA_W = 32;
    localparam int SIZE_W = 5;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ROW,
        ST_COL,
        ST_DONE
    } msp_state_t;

endpackage

`default_nettype wire

// ===== sv/matrix_saddle_point_finder_top.sv =====
// Matrix saddle point finder: stores an n-by-n matrix in a block memory, then
// scans rows for their minimum and checks that value against its column.
// Depends on msp_pkg.
// Elements load at one transfer per cycle into the store while no size write is offered; n*n transfers fill a matrix.
// The result follows the last element's transfer once a search through the single read port
// of the store ends: each row is scanned for its minimum, then that minimum's column is checked.
// Input is held off during the search, and longer while an earlier result is still untaken.
// Reset clears the control state and sets the size to 16 (saturated to MAX_DIM); the
// store contents are undefined after reset and need no clearing pass.
`default_nettype none

module matrix_saddle_point_finder_top
    import msp_pkg::*;
#(
    parameter int MAX_DIM = 16
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     cfg_valid,
    output logic                    cfg_ready,
    input  wire  [SIZE_W-1:0]       cfg_matrix_size,
    input  wire                     s_valid,
    output logic                    s_ready,
    input  wire  signed [DATA_W-1:0] s_element_value,
    output logic                    m_valid,
    input  wire                     m_ready,
    output logic                    m_found,
    output logic signed [DATA_W-1:0] m_saddle_value
);

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = ADDR_W + 1;

    msp_state_t state_reg, state_next;

    logic [SIZE_W-1:0] size_reg, size_next;
    logic [CNT_W-1:0]  load_cnt_reg, load_cnt_next;
    logic [DIM_W-1:0]  row_reg, row_next;
    logic [ADDR_W-1:0] row_base_reg, row_base_next;
    logic [DIM_W-1:0]  step_reg, step_next;
    logic [ADDR_W-1:0] col_addr_reg, col_addr_next;
    logic              pv_reg, pv_next;
    logic              pfirst_reg, pfirst_next;
    logic              plast_reg, plast_next;
    logic [DIM_W-1:0]  pidx_reg, pidx_next;
    logic signed [DATA_W-1:0] best_reg, best_next;
    logic [DIM_W-1:0]  bcol_reg, bcol_next;
    logic              ok_reg, ok_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_found_reg, m_found_next;
    logic signed [DATA_W-1:0] m_value_reg, m_value_next;

    logic [DIM_W-1:0]  dim;
    logic [CNT_W-1:0]  total;
    logic              we;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic signed [DATA_W-1:0] rd_data_reg;
    logic              res_ready;
    logic              final_ok;

    // Matrix store: one write port for loading, one registered read port for the search.
    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= s_element_value;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Size in use: zero acts as one, anything above MAX_DIM saturates.
    always_comb begin
        if (size_reg == '0) begin
            dim = DIM_W'(1);
        end else if (32'(size_reg) > MAX_DIM) begin
            dim = DIM_W'(MAX_DIM);
        end else begin
            dim = DIM_W'(size_reg);
        end
        total = CNT_W'(dim) * CNT_W'(dim);
    end

    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        state_next    = state_reg;
        size_next     = size_reg;
        load_cnt_next = load_cnt_reg;
        row_next      = row_reg;
        row_base_next = row_base_reg;
        step_next     = step_reg;
        col_addr_next = col_addr_reg;
        pv_next       = 1'b0;
        pfirst_next   = pfirst_reg;
        plast_next    = plast_reg;
        pidx_next     = pidx_reg;
        best_next     = best_reg;
        bcol_next     = bcol_reg;
        ok_next       = ok_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_found_next  = m_found_reg;
        m_value_next  = m_value_reg;
        we            = 1'b0;
        wr_addr       = load_cnt_reg[ADDR_W-1:0];
        rd_en         = 1'b0;
        rd_addr       = row_base_reg + ADDR_W'(step_reg);
        s_ready       = 1'b0;
        cfg_ready     = 1'b0;
        final_ok      = 1'b0;

        unique case (state_reg)
            ST_LOAD: begin
                // A size write offered in the same cycle goes first; the element waits.
                s_ready   = !cfg_valid;
                cfg_ready = 1'b1;
                if (s_valid && s_ready) begin
                    we = 1'b1;
                    if (load_cnt_reg + CNT_W'(1) == total) begin
                        load_cnt_next = '0;
                        row_next      = '0;
                        row_base_next = '0;
                        step_next     = '0;
                        state_next    = ST_ROW;
                    end else begin
                        load_cnt_next = load_cnt_reg + CNT_W'(1);
                    end
                end
                // A size write drops any partial matrix.
                if (cfg_valid) begin
                    size_next     = cfg_matrix_size;
                    load_cnt_next = '0;
                    state_next    = ST_LOAD;
                end
            end

            ST_ROW: begin
                if (step_reg < dim) begin
                    rd_en       = 1'b1;
                    rd_addr     = row_base_reg + ADDR_W'(step_reg);
                    step_next   = step_reg + DIM_W'(1);
                    pv_next     = 1'b1;
                    pfirst_next = (step_reg == '0);
                    plast_next  = (step_reg == dim - DIM_W'(1));
                    pidx_next   = step_reg;
                end
                if (pv_reg) begin
                    // Strict compare keeps the leftmost column on ties.
                    if (pfirst_reg || (rd_data_reg < best_reg)) begin
                        best_next = rd_data_reg;
                        bcol_next = pidx_reg;
                    end
                    if (plast_reg) begin
                        step_next     = '0;
                        col_addr_next = ADDR_W'(bcol_next);
                        ok_next       = 1'b1;
                        state_next    = ST_COL;
                    end
                end
            end

            ST_COL: begin
                if (step_reg < dim) begin
                    rd_en         = 1'b1;
                    rd_addr       = col_addr_reg;
                    col_addr_next = col_addr_reg + ADDR_W'(dim);
                    step_next     = step_reg + DIM_W'(1);
                    pv_next       = 1'b1;
                    plast_next    = (step_reg == dim - DIM_W'(1));
                end
                if (pv_reg) begin
                    final_ok = ok_reg && !(best_reg < rd_data_reg);
                    ok_next  = final_ok;
                    if (plast_reg) begin
                        if (final_ok || (row_reg == dim - DIM_W'(1))) begin
                            if (res_ready) begin
                                m_valid_next = 1'b1;
                                m_found_next = final_ok;
                                m_value_next = final_ok ? best_reg : '0;
                                state_next   = ST_LOAD;
                            end else begin
                                state_next = ST_DONE;
                            end
                        end else begin
                            row_next      = row_reg + DIM_W'(1);
                            row_base_next = row_base_reg + ADDR_W'(dim);
                            step_next     = '0;
                            state_next    = ST_ROW;
                        end
                    end
                end
            end

            ST_DONE: begin
                // The previous result has not been taken yet.
                if (res_ready) begin
                    m_valid_next = 1'b1;
                    m_found_next = ok_reg;
                    m_value_next = ok_reg ? best_reg : '0;
                    state_next   = ST_LOAD;
                end
            end

            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            size_reg     <= SIZE_RESET;
            load_cnt_reg <= '0;
            row_reg      <= '0;
            row_base_reg <= '0;
            step_reg     <= '0;
            pv_reg       <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            size_reg     <= size_next;
            load_cnt_reg <= load_cnt_next;
            row_reg      <= row_next;
            row_base_reg <= row_base_next;
            step_reg     <= step_next;
            pv_reg       <= pv_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        col_addr_reg <= col_addr_next;
        pfirst_reg   <= pfirst_next;
        plast_reg    <= plast_next;
        pidx_reg     <= pidx_next;
        best_reg     <= best_next;
        bcol_reg     <= bcol_next;
        ok_reg       <= ok_next;
        m_found_reg  <= m_found_next;
        m_value_reg  <= m_value_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_found        = m_found_reg;
    assign m_saddle_value = m_value_reg;

    // The store is never written and read in the same cycle.
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(we && rd_en))
        else $error("store written and read in the same cycle");

    // The scan counters stay within the matrix in use.
    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROW || state_reg == ST_COL) |-> (step_reg <= dim))
        else $error("scan step beyond matrix size");

    a_row_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROW || state_reg == ST_COL) |-> (row_reg < dim))
        else $error("row index beyond matrix size");

    // A not-found result carries a zero value.
    a_notfound_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_found_reg) |-> (m_value_reg == '0))
        else $error("not-found result with non-zero value");

    // A fresh result is only issued at the end of a column check or from the wait state.
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !$past(m_valid_reg)) |->
            ($past(state_reg) == ST_COL || $past(state_reg) == ST_DONE))
        else $error("result issued outside the search");

endmodule

`default_nettype wire
